@@ src/cdq_pkg.sv @@
package cdq_pkg;

    localparam int MAX_UNITS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int INDEX_W       = 32;
    localparam int UNIT_ID_W     = 8;
    localparam int UNIT_COUNT_W  = 4;
    localparam int DIGIT_W       = 4;
    localparam int KEY_STEPS     = INDEX_W / DIGIT_W;
    localparam int UID_STEPS     = UNIT_ID_W / DIGIT_W;
    localparam int STEP_W        = $clog2(KEY_STEPS);
    localparam int CMD_FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_SUBMIT  = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_CLOSE   = 2'd2,
        OP_STOP    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_RETRY    = 3'd1,
        ST_FINISHED = 3'd2,
        ST_STOPPED  = 3'd3,
        ST_ACCEPTED = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        REG_POLICY_MODE = 1'b0,
        REG_UNIT_COUNT  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        opcode_t                opcode;
        logic [INDEX_W-1:0]     block_index;
        logic [UNIT_ID_W-1:0]   unit_id;
    } cmd_t;

    typedef struct packed {
        status_t                status;
        logic [INDEX_W-1:0]     granted_index;
        logic                   stop_flag;
    } rsp_t;

    typedef struct packed {
        logic                    policy_mode;
        logic [UNIT_COUNT_W-1:0] unit_count;
    } dispatch_cfg_t;

    typedef struct packed {
        opcode_t                 opcode;
        logic [INDEX_W-1:0]      block_index;
        logic [UNIT_COUNT_W-1:0] queue_sel;
    } work_t;

    typedef struct packed {
        logic busy;
        logic stopped;
    } back_stat_t;

endpackage

@@ src/cdq_ram.sv @@
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/cdq_front.sv @@
module cdq_front #(
    parameter int MAX_UNITS = cdq_pkg::MAX_UNITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cdq_pkg::dispatch_cfg_t cfg,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cdq_pkg::cmd_t         cmd,
    output logic                  work_valid,
    input  logic                  work_ready,
    output cdq_pkg::work_t        work
);

    import cdq_pkg::*;

    typedef enum logic [2:0] {
        FE_IDLE = 3'b001,
        FE_CALC = 3'b010,
        FE_PUSH = 3'b100
    } fe_state_t;

    fe_state_t               state_reg;
    fe_state_t               state_next;
    opcode_t                 op_reg;
    logic [INDEX_W-1:0]      index_reg;
    logic [INDEX_W-1:0]      key_reg;
    logic [UNIT_COUNT_W-1:0] rem_reg;
    logic [STEP_W-1:0]       steps_reg;

    logic [UNIT_COUNT_W-1:0] eff_count;
    logic [UNIT_COUNT_W:0]   trial;
    logic [UNIT_COUNT_W-1:0] rem_acc;
    logic                    accept;
    logic                    partitioned;

    // zero means one, above the bank saturates
    always_comb
    begin
        if (cfg.unit_count == '0)
        begin
            eff_count = UNIT_COUNT_W'(1);
        end
        else if (int'(cfg.unit_count) > MAX_UNITS)
        begin
            eff_count = UNIT_COUNT_W'(MAX_UNITS);
        end
        else
        begin
            eff_count = cfg.unit_count;
        end
    end

    // one digit of the remainder, msb first
    always_comb
    begin
        trial   = '0;
        rem_acc = rem_reg;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            trial = {rem_acc, key_reg[INDEX_W-1-i]};
            if (trial >= {1'b0, eff_count})
            begin
                trial = trial - {1'b0, eff_count};
            end
            rem_acc = trial[UNIT_COUNT_W-1:0];
        end
    end

    assign accept      = cmd_valid && (state_reg == FE_IDLE);
    assign partitioned = cfg.policy_mode &&
                         ((cmd.opcode == OP_SUBMIT) || (cmd.opcode == OP_ACQUIRE));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE:
            begin
                if (accept)
                begin
                    state_next = partitioned ? FE_CALC : FE_PUSH;
                end
            end
            FE_CALC:
            begin
                if (steps_reg == '0)
                begin
                    state_next = FE_PUSH;
                end
            end
            FE_PUSH:
            begin
                if (work_ready)
                begin
                    state_next = FE_IDLE;
                end
            end
            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= cmd.opcode;
            index_reg <= cmd.block_index;
            rem_reg   <= '0;
            if (cmd.opcode == OP_ACQUIRE)
            begin
                key_reg   <= {cmd.unit_id, {(INDEX_W-UNIT_ID_W){1'b0}}};
                steps_reg <= STEP_W'(UID_STEPS - 1);
            end
            else
            begin
                key_reg   <= cmd.block_index;
                steps_reg <= STEP_W'(KEY_STEPS - 1);
            end
        end
        else if (state_reg == FE_CALC)
        begin
            rem_reg   <= rem_acc;
            key_reg   <= key_reg << DIGIT_W;
            steps_reg <= steps_reg - 1'b1;
        end
    end

    assign cmd_stall        = (state_reg != FE_IDLE);
    assign work_valid       = (state_reg == FE_PUSH);
    assign work.opcode      = op_reg;
    assign work.block_index = index_reg;
    assign work.queue_sel   = rem_reg;

endmodule

@@ src/cdq_cmd_fifo.sv @@
module cdq_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  cdq_pkg::work_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output cdq_pkg::work_t pop_data
);

    import cdq_pkg::*;

    localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    work_t            entry_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(CMD_FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/cdq_back.sv @@
module cdq_back #(
    parameter int MAX_UNITS   = cdq_pkg::MAX_UNITS_DEF,
    parameter int QUEUE_DEPTH = cdq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                work_valid,
    output logic                work_ready,
    input  cdq_pkg::work_t      work,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output cdq_pkg::rsp_t       rsp,
    output cdq_pkg::back_stat_t stat
);

    import cdq_pkg::*;

    localparam int SEL_W       = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_DEPTH = MAX_UNITS * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam logic [ADDR_W:0]  DEPTH_A = (ADDR_W+1)'(QUEUE_DEPTH);
    localparam logic [PTR_W:0]   DEPTH_S = (PTR_W+1)'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_READ = 2'b10
    } bk_state_t;

    bk_state_t         state_reg;
    bk_state_t         state_next;
    logic [PTR_W-1:0]  head_reg [MAX_UNITS];
    logic [FILL_W-1:0] fill_reg [MAX_UNITS];
    logic              closed_reg;
    logic              closed_next;
    logic              stop_reg;
    logic              stop_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic              out_free;
    logic              take;
    logic [SEL_W-1:0]  sel;
    logic [PTR_W-1:0]  head_sel;
    logic [FILL_W-1:0] fill_sel;
    logic [PTR_W:0]    slot_sum;
    logic [PTR_W-1:0]  slot;
    logic [ADDR_W:0]   base;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              full;
    logic              head_we;
    logic [PTR_W-1:0]  head_wdata;
    logic              fill_we;
    logic [FILL_W-1:0] fill_wdata;
    logic              ram_we;
    logic              ram_re;
    logic [INDEX_W-1:0] ram_rdata;

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign work_ready = (state_reg == BK_IDLE) && out_free;
    assign take       = work_valid && work_ready;

    assign sel      = SEL_W'(work.queue_sel);
    assign head_sel = head_reg[sel];
    assign fill_sel = fill_reg[sel];
    assign full     = (fill_sel == FILL_W'(QUEUE_DEPTH));

    // tail slot wraps at most once
    assign slot_sum = (PTR_W+1)'(head_sel) + (PTR_W+1)'(fill_sel);
    assign slot     = (slot_sum >= DEPTH_S) ? PTR_W'(slot_sum - DEPTH_S) : PTR_W'(slot_sum);
    assign base     = (ADDR_W+1)'(sel) * DEPTH_A;
    assign wr_addr  = ADDR_W'(base + (ADDR_W+1)'(slot));
    assign rd_addr  = ADDR_W'(base + (ADDR_W+1)'(head_sel));

    always_comb
    begin
        state_next     = state_reg;
        closed_next    = closed_reg;
        stop_next      = stop_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        head_we        = 1'b0;
        head_wdata     = (head_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_sel + 1'b1;
        fill_we        = 1'b0;
        fill_wdata     = fill_sel;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (take)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: ST_ACCEPTED, granted_index: '0,
                                       stop_flag: stop_reg};
                    case (work.opcode)
                        OP_SUBMIT:
                        begin
                            if (full)
                            begin
                                rsp_next.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                fill_we    = 1'b1;
                                fill_wdata = fill_sel + 1'b1;
                            end
                        end
                        OP_ACQUIRE:
                        begin
                            if (stop_reg)
                            begin
                                rsp_next.status = ST_STOPPED;
                            end
                            else if (fill_sel != '0)
                            begin
                                // grant comes out of the store next cycle
                                rsp_valid_next = 1'b0;
                                ram_re         = 1'b1;
                                head_we        = 1'b1;
                                fill_we        = 1'b1;
                                fill_wdata     = fill_sel - 1'b1;
                                state_next     = BK_READ;
                            end
                            else if (closed_reg)
                            begin
                                rsp_next.status = ST_FINISHED;
                            end
                            else
                            begin
                                rsp_next.status = ST_RETRY;
                            end
                        end
                        OP_CLOSE:
                        begin
                            closed_next = 1'b1;
                        end
                        OP_STOP:
                        begin
                            stop_next          = 1'b1;
                            rsp_next.stop_flag = 1'b1;
                        end
                        default:
                        begin
                            rsp_valid_next = rsp_valid_reg && rsp_stall;
                            rsp_next       = rsp_reg;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = '{status: ST_GRANTED, granted_index: ram_rdata,
                                   stop_flag: stop_reg};
                state_next     = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            closed_reg    <= 1'b0;
            stop_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_UNITS; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            closed_reg    <= closed_next;
            stop_reg      <= stop_next;
            rsp_valid_reg <= rsp_valid_next;
            if (head_we)
            begin
                head_reg[sel] <= head_wdata;
            end
            if (fill_we)
            begin
                fill_reg[sel] <= fill_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    cdq_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (work.block_index),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;
    assign stat.busy    = (state_reg != BK_IDLE);
    assign stat.stopped = stop_reg;

endmodule

@@ src/cta_dispatch_queue_bank_unit.sv @@
// channel   dir  handshake                   payload
// cmd       in   cmd_valid / cmd_stall       cmd (opcode, block_index, unit_id)
// rsp       out  rsp_valid / rsp_stall       rsp (status, granted_index, stop_flag)
// cfg       in   cfg_valid / cfg_ready       cfg_index, cfg_data
//
// the front takes a new command only after pushing the last one; in fifo mode and for
// close and stop it goes straight to push, in partitioned mode the remainder unit takes
// 4 bits a cycle, a submit over the whole block_index, an acquire over unit_id alone
// the back end registers each answer, a granted acquire after one store read
// reset clears head, fill, close and stop state at once; the store needs no sweep
// a two-entry command queue lets cmd keep moving while rsp is stalled, until it fills
module cta_dispatch_queue_bank_unit #(
    parameter int MAX_UNITS   = cdq_pkg::MAX_UNITS_DEF,
    parameter int QUEUE_DEPTH = cdq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_stall,
    input  cdq_pkg::cmd_t                         cmd,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output cdq_pkg::rsp_t                         rsp,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  cdq_pkg::cfg_reg_t                     cfg_index,
    input  logic [cdq_pkg::UNIT_COUNT_W-1:0]      cfg_data
);

    import cdq_pkg::*;

    logic                    policy_mode_reg;
    logic                    policy_mode_next;
    logic [UNIT_COUNT_W-1:0] unit_count_reg;
    logic [UNIT_COUNT_W-1:0] unit_count_next;
    dispatch_cfg_t           cfg;

    logic                    fe_valid;
    logic                    fe_ready;
    work_t                   fe_work;
    logic                    bk_valid;
    logic                    bk_ready;
    work_t                   bk_work;
    back_stat_t              bk_stat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        policy_mode_next = policy_mode_reg;
        unit_count_next  = unit_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POLICY_MODE:
                begin
                    policy_mode_next = cfg_data[0];
                end
                REG_UNIT_COUNT:
                begin
                    unit_count_next = cfg_data;
                end
                default:
                begin
                    policy_mode_next = policy_mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_mode_reg <= 1'b0;
            unit_count_reg  <= UNIT_COUNT_W'(1);
        end
        else
        begin
            policy_mode_reg <= policy_mode_next;
            unit_count_reg  <= unit_count_next;
        end
    end

    assign cfg.policy_mode = policy_mode_reg;
    assign cfg.unit_count  = unit_count_reg;

    cdq_front #(
        .MAX_UNITS (MAX_UNITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .work_valid (fe_valid),
        .work_ready (fe_ready),
        .work       (fe_work)
    );

    cdq_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (fe_work),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_data   (bk_work)
    );

    cdq_back #(
        .MAX_UNITS   (MAX_UNITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (bk_valid),
        .work_ready (bk_ready),
        .work       (bk_work),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .stat       (bk_stat)
    );

`ifndef SYNTH
    a_cmd_holds_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("front took a second command back to back");

    a_read_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.busy |-> !rsp_valid)
        else $error("store read pending while a response is held");

    a_index_zero_unless_granted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_GRANTED) |-> (rsp.granted_index == '0))
        else $error("index on a response that is not a grant");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.stopped |=> bk_stat.stopped)
        else $error("stop flag cleared without reset");

    a_stopped_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_STOPPED) |-> rsp.stop_flag)
        else $error("stopped answer without stop flag");
`endif

endmodule
